// File: design/mlbbs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlbbs_pkg: shared types and constants for the LED blink/breathe scheduler
// Mode bit positions, command codes and sequencer states.
// ---------------------------------------------------------------------------
package mlbbs_pkg;

  localparam int unsigned NumLedsDef   = 8;
  localparam int unsigned MaxBrightDef = 32;
  localparam int unsigned Lanes        = 8;

  localparam int unsigned ModeOn      = 0;
  localparam int unsigned ModeBlink   = 1;
  localparam int unsigned ModeFlash   = 2;
  localparam int unsigned ModeBreathe = 3;
  localparam int unsigned ModeCont    = 4;

  typedef enum logic [2:0] {
    CMD_ON       = 3'd0,
    CMD_OFF      = 3'd1,
    CMD_TOGGLE   = 3'd2,
    CMD_BLINK    = 3'd3,
    CMD_BREATHE  = 3'd4,
    CMD_UPD_BLNK = 3'd5,
    CMD_UPD_BRTH = 3'd6,
    CMD_NONE     = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL,
    ST_EMIT
  } state_e;

  // Request to the shared division unit: period / 100.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// File: design/multi_led_blink_breathe_scheduler_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_led_blink_breathe_scheduler_core
// Per-LED on/off, blink and breathe scheduler with wrap-safe timing.
// ---------------------------------------------------------------------------
// Usage: drive the request fields and raise start while busy is low; the
// request is taken at that rising edge.
// On, off, toggle, blink and breathe requests update the LED records at the
// accepting edge and produce no result; busy stays low, so such requests
// can follow on every cycle.
// Update requests (blink or breathe) walk the LED records through a shared
// datapath, one per cycle unless a divide step holds the walk, then emit one
// result per LED on consecutive cycles, each marked by valid_o; the last one
// carries next_wait_o, all_idle_o and last_result_o.
// Busy spans a walk step per LED, plus a divide step for each LED whose
// blink phase changes (divide by 100 through a reciprocal multiply, then
// scale by the phase percent), plus a result step per LED. The next
// request is taken in the cycle after the last result. Worst case is when
// every LED changes blink phase.
// Reset clears every LED record and the lit mask: all LEDs off.
// The receiver cannot stall; results appear exactly once, on schedule.
// ---------------------------------------------------------------------------
module multi_led_blink_breathe_scheduler_core
  import mlbbs_pkg::*;
#(
  parameter int unsigned NUM_LEDS   = NumLedsDef,
  parameter int unsigned MAX_BRIGHT = MaxBrightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [7:0]  led_mask_i,
  input  logic [7:0]  repeat_count_i,
  input  logic [7:0]  on_percent_i,
  input  logic [31:0] cycle_period_i,
  input  logic [31:0] breathe_step_i,
  input  logic [31:0] now_time_i,
  output logic        valid_o,
  output logic [2:0]  led_index_o,
  output logic        led_lit_o,
  output logic [5:0]  brightness_o,
  output logic [7:0]  lit_mask_o,
  output logic [31:0] next_wait_o,
  output logic        all_idle_o,
  output logic        last_result_o
);

  localparam int unsigned Active = (NUM_LEDS > Lanes) ? Lanes : NUM_LEDS;
  localparam logic [5:0]  MaxB   = 6'(MAX_BRIGHT);
  localparam logic [2:0]  LastIx = 3'(Active - 1);
  localparam logic [7:0]  ActMask = 8'((9'd1 << Active) - 9'd1);

  logic [4:0]  mode_q   [Lanes];
  logic [7:0]  cyc_q    [Lanes];
  logic [6:0]  duty_q   [Lanes];
  logic [5:0]  bright_q [Lanes];
  logic [31:0] pleft_q  [Lanes];
  logic [31:0] psave_q  [Lanes];
  logic [31:0] step_q   [Lanes];
  logic [31:0] due_q    [Lanes];
  logic [7:0]  lit_q;

  state_e      state_q, state_d;
  logic [2:0]  idx_q, idx_d;
  logic        upd_blink_q;
  logic [31:0] now_q;
  logic [31:0] next_q;
  logic [31:0] bl_wait;
  logic [6:0]  pct_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  mlbbs_div100 u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  cmd_e        cmd;
  logic [7:0]  mask;
  logic        accept;
  logic [4:0]  m;
  logic [31:0] diff;
  logic        due_now;
  logic        lane_act;

  assign cmd     = cmd_e'(command_i);
  assign mask    = led_mask_i & ActMask;
  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign m       = mode_q[idx_q];
  assign diff    = due_q[idx_q] - now_q;
  // act only once the due time has strictly passed
  assign due_now = diff[31];
  assign lane_act = upd_blink_q ? m[ModeBlink] : m[ModeBreathe];

  // Blink phase decision for the current lane.
  logic [4:0] bl_mode;
  logic [6:0] bl_pct;
  always_comb begin
    bl_mode = m;
    bl_pct  = '0;
    if (m[ModeOn]) begin
      bl_pct  = 7'(7'd100 - duty_q[idx_q]);
      bl_mode[ModeOn] = 1'b0;
    end else if (cyc_q[idx_q] == 8'd0 && !m[ModeFlash]) begin
      bl_mode[ModeBlink] = 1'b0;
    end else begin
      bl_pct  = duty_q[idx_q];
      bl_mode[ModeOn] = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    div_req.start    = 1'b0;
    div_req.dividend = psave_q[idx_q];
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept && (cmd == CMD_UPD_BLNK || cmd == CMD_UPD_BRTH)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (lane_act && due_now && upd_blink_q && bl_mode[ModeBlink]) begin
          div_req.start = 1'b1;
          state_d = ST_MUL;
        end else if (idx_q == LastIx) begin
          idx_d = '0;
          state_d = ST_EMIT;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      ST_MUL: begin
        if (div_rsp.done) begin
          if (idx_q == LastIx) begin
            idx_d = '0;
            state_d = ST_EMIT;
          end else begin
            idx_d = idx_q + 3'd1;
            state_d = ST_WALK;
          end
        end
      end
      ST_EMIT: begin
        if (idx_q == LastIx) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Minimum fold: take wait when nothing yet, or a smaller nonzero one.
  function automatic logic [31:0] fold(input logic [31:0] cur, input logic [31:0] w);
    if (cur == 32'd0 || (w != 32'd0 && w < cur)) begin
      return w;
    end
    return cur;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      lit_q   <= '0;
      next_q  <= '0;
      for (int i = 0; i < Lanes; i++) begin
        mode_q[i]   <= '0;
        cyc_q[i]    <= '0;
        duty_q[i]   <= '0;
        bright_q[i] <= '0;
        pleft_q[i]  <= '0;
        psave_q[i]  <= '0;
        step_q[i]   <= '0;
        due_q[i]    <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (state_q == ST_IDLE && accept) begin
        next_q <= '0;
        for (int i = 0; i < Lanes; i++) begin
          if (mask[i]) begin
            priority case (cmd)
              CMD_ON: begin
                mode_q[i] <= 5'(1 << ModeOn);
                lit_q[i]  <= 1'b1;
              end
              CMD_OFF: begin
                mode_q[i] <= '0;
                lit_q[i]  <= 1'b0;
              end
              CMD_TOGGLE: begin
                mode_q[i] <= mode_q[i] ^ 5'(1 << ModeOn);
                lit_q[i]  <= ((mode_q[i] ^ 5'(1 << ModeOn)) != 5'd0);
              end
              CMD_BLINK: begin
                if (on_percent_i != 8'd0 && cycle_period_i != 32'd0) begin
                  if (on_percent_i <= 8'd100) begin
                    psave_q[i] <= cycle_period_i;
                    duty_q[i]  <= on_percent_i[6:0];
                    cyc_q[i]   <= repeat_count_i;
                    due_q[i]   <= now_time_i;
                    mode_q[i]  <= 5'(1 << ModeBlink) |
                                  ((repeat_count_i == 8'd0) ? 5'(1 << ModeFlash) : 5'd0);
                  end
                end else begin
                  mode_q[i] <= '0;
                  lit_q[i]  <= 1'b0;
                end
              end
              CMD_BREATHE: begin
                if (breathe_step_i != 32'd0 && cycle_period_i != 32'd0) begin
                  bright_q[i] <= '0;
                  pleft_q[i]  <= cycle_period_i;
                  psave_q[i]  <= cycle_period_i;
                  step_q[i]   <= breathe_step_i;
                  cyc_q[i]    <= repeat_count_i;
                  due_q[i]    <= now_time_i;
                  mode_q[i]   <= 5'(1 << ModeBreathe) |
                                 ((repeat_count_i == 8'd0) ? 5'(1 << ModeCont) : 5'd0);
                end else begin
                  mode_q[i] <= '0;
                  lit_q[i]  <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
      end else if (state_q == ST_WALK && lane_act) begin
        if (!due_now) begin
          next_q <= fold(next_q, diff);
        end else if (upd_blink_q) begin
          if (!bl_mode[ModeBlink]) begin
            mode_q[idx_q] <= '0;
            lit_q[idx_q]  <= 1'b0;
            next_q <= fold(next_q, 32'd0);
          end else begin
            mode_q[idx_q] <= bl_mode;
            if (m[ModeOn]) begin
              lit_q[idx_q] <= 1'b0;
              if (!m[ModeFlash]) cyc_q[idx_q] <= cyc_q[idx_q] - 8'd1;
            end else begin
              lit_q[idx_q] <= 1'b1;
            end
          end
        end else begin
          if (pleft_q[idx_q] != 32'd0) begin
            bright_q[idx_q] <= (bright_q[idx_q] < MaxB) ? bright_q[idx_q] + 6'd1 : MaxB;
            lit_q[idx_q] <= 1'b1;
            pleft_q[idx_q] <= (pleft_q[idx_q] > step_q[idx_q]) ?
                              pleft_q[idx_q] - step_q[idx_q] : 32'd0;
            due_q[idx_q] <= now_q + step_q[idx_q];
            next_q <= fold(next_q, step_q[idx_q]);
          end else if (!m[ModeCont]) begin
            pleft_q[idx_q] <= psave_q[idx_q];
            cyc_q[idx_q]   <= cyc_q[idx_q] - 8'd1;
            if (cyc_q[idx_q] == 8'd1) begin
              mode_q[idx_q] <= 5'(1 << ModeOn);
              lit_q[idx_q]  <= 1'b1;
              next_q <= fold(next_q, 32'd0);
            end else begin
              due_q[idx_q] <= now_q + step_q[idx_q];
              next_q <= fold(next_q, step_q[idx_q]);
            end
          end else begin
            pleft_q[idx_q] <= psave_q[idx_q];
            due_q[idx_q] <= now_q + step_q[idx_q];
            next_q <= fold(next_q, step_q[idx_q]);
          end
        end
      end else if (state_q == ST_MUL && div_rsp.done) begin
        // wait = (period / 100) * pct
        due_q[idx_q] <= now_q + bl_wait;
        next_q <= fold(next_q, bl_wait);
      end
    end
  end

  // Capture request context and the blink phase percent.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      upd_blink_q <= (cmd == CMD_UPD_BLNK);
      now_q       <= now_time_i;
    end
    if (state_q == ST_WALK) begin
      pct_q <= bl_pct;
    end
  end

  // Scale the quotient on the done cycle.
  assign bl_wait = div_rsp.quotient * {25'd0, pct_q};

  always_comb begin
    valid_o       = (state_q == ST_EMIT);
    led_index_o   = idx_q;
    led_lit_o     = lit_q[idx_q];
    brightness_o  = bright_q[idx_q];
    lit_mask_o    = lit_q;
    last_result_o = valid_o && (idx_q == LastIx);
    next_wait_o   = last_result_o ? next_q : 32'd0;
    all_idle_o    = last_result_o && (next_q == 32'd0);
  end

`ifndef ASSERT_OFF
  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !valid_o) else $error("result while idle");
  a_last_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_result_o |=> !busy) else $error("busy after last result");
  a_lit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lit_q & ~ActMask) == 8'd0) else $error("lit bit beyond LED count");
  a_idx_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_result_o) |=> (valid_o && idx_q == $past(idx_q) + 3'd1))
    else $error("result index skipped");
`endif

endmodule

// File: design/mlbbs_div100.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlbbs_div100: divide by 100
// Reciprocal multiply with a registered quotient; a new request may start while the last one completes.
// ---------------------------------------------------------------------------
module mlbbs_div100
  import mlbbs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  // ceil(2^37 / 100): the top bits of the product give the exact floor
  // quotient for every 32-bit dividend
  localparam logic [31:0] Recip = 32'h51EB_851F;

  logic [63:0] prod;
  logic [31:0] quo_q, quo_d;
  logic        done_q, done_d;

  assign prod   = 64'(req_i.dividend) * 64'(Recip);
  assign quo_d  = req_i.start ? 32'(prod >> 37) : quo_q;
  assign done_d = req_i.start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
